>>> rtl/core/sorted_keyed_latest_table_unit_defines.svh
// Assertion macros for the sorted keyed latest table unit
`ifndef SORTED_KEYED_LATEST_TABLE_UNIT_DEFINES_SVH
`define SORTED_KEYED_LATEST_TABLE_UNIT_DEFINES_SVH

// check a property on a named clock and active-low reset
`define SKLT_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check a property on the block clock and reset
`define SKLT_ASSERT(label, prop, msg) \
  `SKLT_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/core/sklt_pkg.sv
// Package: shared types and constants of the sorted keyed latest table unit
`timescale 1ns / 1ps
`default_nettype none

package sklt_pkg;

  localparam int KeyW    = 64;
  localparam int TimeW   = 32;
  localparam int HandleW = 16;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DRAIN  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    STATUS_ADDED    = 3'd0,
    STATUS_REPLACED = 3'd1,
    STATUS_KEPT     = 3'd2,
    STATUS_IGNORED  = 3'd3,
    STATUS_FULL     = 3'd4,
    STATUS_DRAINED  = 3'd5
  } status_e;

  typedef struct packed {
    cmd_e               command;
    logic [KeyW-1:0]    item_key;
    logic [TimeW-1:0]   check_time;
    logic [HandleW-1:0] message_handle;
    logic               message_present;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [KeyW-1:0]    out_key;
    logic [TimeW-1:0]   out_time;
    logic [HandleW-1:0] out_handle;
    logic               entry_valid;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic insert;
    logic replace;
    logic shift_out;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/core/sklt_cell.sv
// Table cell: one sorted entry with its compare flags and neighbor shifting
`timescale 1ns / 1ps
`default_nettype none

module sklt_cell #(
  parameter int HandleBits = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  sklt_pkg::cell_ctrl_t         ctrl_i,
  input  wire  [sklt_pkg::KeyW-1:0]    item_key_i,
  input  wire  [sklt_pkg::TimeW-1:0]   item_time_i,
  input  wire  [HandleBits-1:0]        item_handle_i,
  input  wire                          left_lt_i,
  input  wire                          left_occ_i,
  input  wire  [sklt_pkg::KeyW-1:0]    left_key_i,
  input  wire  [sklt_pkg::TimeW-1:0]   left_time_i,
  input  wire  [HandleBits-1:0]        left_handle_i,
  input  wire                          right_occ_i,
  input  wire  [sklt_pkg::KeyW-1:0]    right_key_i,
  input  wire  [sklt_pkg::TimeW-1:0]   right_time_i,
  input  wire  [HandleBits-1:0]        right_handle_i,
  output logic                         occ_o,
  output logic [sklt_pkg::KeyW-1:0]    key_o,
  output logic [sklt_pkg::TimeW-1:0]   time_o,
  output logic [HandleBits-1:0]        handle_o,
  output logic                         lt_o,
  output logic                         eq_o,
  output logic                         later_o
);

  logic                        occ_q, occ_d;
  logic [sklt_pkg::KeyW-1:0]   key_q, key_d;
  logic [sklt_pkg::TimeW-1:0]  time_q, time_d;
  logic [HandleBits-1:0]       handle_q, handle_d;
  logic                        lt_q, lt_d;
  logic                        eq_q, eq_d;
  logic                        later_q, later_d;

  always_comb begin
    occ_d    = occ_q;
    key_d    = key_q;
    time_d   = time_q;
    handle_d = handle_q;
    if (ctrl_i.shift_out) begin
      occ_d    = right_occ_i;
      key_d    = right_key_i;
      time_d   = right_time_i;
      handle_d = right_handle_i;
    end else if (ctrl_i.insert && !lt_q) begin
      if (left_lt_i) begin
        occ_d    = 1'b1;
        key_d    = item_key_i;
        time_d   = item_time_i;
        handle_d = item_handle_i;
      end else begin
        occ_d    = left_occ_i;
        key_d    = left_key_i;
        time_d   = left_time_i;
        handle_d = left_handle_i;
      end
    end else if (ctrl_i.replace && eq_q && later_q) begin
      time_d   = item_time_i;
      handle_d = item_handle_i;
    end
  end

  assign lt_d    = occ_q && (key_q < item_key_i);
  assign eq_d    = occ_q && (key_q == item_key_i);
  assign later_d = time_q < item_time_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= 1'b0;
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
      later_q <= 1'b0;
    end else begin
      occ_q   <= occ_d;
      lt_q    <= lt_d;
      eq_q    <= eq_d;
      later_q <= later_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    time_q   <= time_d;
    handle_q <= handle_d;
  end

  assign occ_o    = occ_q;
  assign key_o    = key_q;
  assign time_o   = time_q;
  assign handle_o = handle_q;
  assign lt_o     = lt_q;
  assign eq_o     = eq_q;
  assign later_o  = later_q;

endmodule

`default_nettype wire

>>> rtl/core/sorted_keyed_latest_table_unit.sv
// Sorted keyed latest table: chain of entry cells, insert by shift, drain by shift
// Insert: the item, the compare flags and then the result are registered in turn; the update waits while
// the output is stalled, and no new item is taken before the result. Flags of every cell register together.
// Drain: one entry per cycle from the head cell while the output is not stalled; an empty table gives one result.
// Reset clears occupancy of every cell at once; no clearing pass, no item held back.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_keyed_latest_table_unit_defines.svh"

module sorted_keyed_latest_table_unit #(
  parameter int TABLE_DEPTH = 64,
  parameter int HANDLE_BITS = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  sklt_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output sklt_pkg::out_item_t  out_item_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CMP   = 4'b0010,
    ST_UPD   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  sklt_pkg::in_item_t   item_q;
  sklt_pkg::out_item_t  out_item_q, out_item_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;
  logic                 in_xfer;
  logic                 hit, repl, full;
  sklt_pkg::cell_ctrl_t ctrl;

  logic [HANDLE_BITS-1:0]       item_handle;
  logic [sklt_pkg::HandleW-1:0] head_handle;

  logic [TABLE_DEPTH-1:0]     occ_vec, lt_vec, eq_vec, later_vec;
  logic [sklt_pkg::KeyW-1:0]  key_arr    [TABLE_DEPTH];
  logic [sklt_pkg::TimeW-1:0] time_arr   [TABLE_DEPTH];
  logic [HANDLE_BITS-1:0]     handle_arr [TABLE_DEPTH];

  if (HANDLE_BITS >= sklt_pkg::HandleW) begin : g_hw_wide
    assign item_handle = HANDLE_BITS'(item_q.message_handle);
    assign head_handle = handle_arr[0][sklt_pkg::HandleW-1:0];
  end else begin : g_hw_narrow
    assign item_handle = item_q.message_handle[HANDLE_BITS-1:0];
    assign head_handle = sklt_pkg::HandleW'(handle_arr[0]);
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic                        left_lt, left_occ, right_occ;
    logic [sklt_pkg::KeyW-1:0]   left_key, right_key;
    logic [sklt_pkg::TimeW-1:0]  left_time, right_time;
    logic [HANDLE_BITS-1:0]      left_handle, right_handle;

    if (i == 0) begin : g_head
      assign left_lt     = 1'b1;
      assign left_occ    = 1'b0;
      assign left_key    = '0;
      assign left_time   = '0;
      assign left_handle = '0;
    end else begin : g_mid
      assign left_lt     = lt_vec[i-1];
      assign left_occ    = occ_vec[i-1];
      assign left_key    = key_arr[i-1];
      assign left_time   = time_arr[i-1];
      assign left_handle = handle_arr[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign right_occ    = 1'b0;
      assign right_key    = '0;
      assign right_time   = '0;
      assign right_handle = '0;
    end else begin : g_body
      assign right_occ    = occ_vec[i+1];
      assign right_key    = key_arr[i+1];
      assign right_time   = time_arr[i+1];
      assign right_handle = handle_arr[i+1];
    end

    sklt_cell #(
      .HandleBits(HANDLE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .item_key_i    (item_q.item_key),
      .item_time_i   (item_q.check_time),
      .item_handle_i (item_handle),
      .left_lt_i     (left_lt),
      .left_occ_i    (left_occ),
      .left_key_i    (left_key),
      .left_time_i   (left_time),
      .left_handle_i (left_handle),
      .right_occ_i   (right_occ),
      .right_key_i   (right_key),
      .right_time_i  (right_time),
      .right_handle_i(right_handle),
      .occ_o         (occ_vec[i]),
      .key_o         (key_arr[i]),
      .time_o        (time_arr[i]),
      .handle_o      (handle_arr[i]),
      .lt_o          (lt_vec[i]),
      .eq_o          (eq_vec[i]),
      .later_o       (later_vec[i])
    );
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign hit        = |eq_vec;
  assign repl       = |(eq_vec & later_vec);
  assign full       = occ_vec[TABLE_DEPTH-1];

  always_comb begin
    ctrl.insert    = (state_q == ST_UPD) && out_free
                     && (item_q.command == sklt_pkg::CMD_INSERT)
                     && item_q.message_present && !hit && !full;
    ctrl.replace   = (state_q == ST_UPD) && out_free
                     && (item_q.command == sklt_pkg::CMD_INSERT)
                     && item_q.message_present && hit;
    ctrl.shift_out = (state_q == ST_DRAIN) && out_free && occ_vec[0];
  end

  always_comb begin
    state_d     = state_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = (in_item_i.command == sklt_pkg::CMD_DRAIN) ? ST_DRAIN : ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_item_d       = '0;
          out_item_d.last  = 1'b1;
          if (!item_q.message_present) begin
            out_item_d.status = sklt_pkg::STATUS_IGNORED;
          end else if (hit) begin
            out_item_d.status = repl ? sklt_pkg::STATUS_REPLACED : sklt_pkg::STATUS_KEPT;
          end else if (full) begin
            out_item_d.status = sklt_pkg::STATUS_FULL;
          end else begin
            out_item_d.status = sklt_pkg::STATUS_ADDED;
          end
          state_d = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_item_d        = '0;
          out_item_d.status = sklt_pkg::STATUS_DRAINED;
          if (occ_vec[0]) begin
            out_item_d.out_key     = key_arr[0];
            out_item_d.out_time    = time_arr[0];
            out_item_d.out_handle  = head_handle;
            out_item_d.entry_valid = 1'b1;
            out_item_d.last        = !occ_vec[1];
            if (!occ_vec[1]) begin
              state_d = ST_IDLE;
            end
          end else begin
            out_item_d.last = 1'b1;
            state_d         = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_item_i;
    end
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `SKLT_ASSERT(a_key_unique, $onehot0(eq_vec), "more than one cell matches the key")
  `SKLT_ASSERT(a_occ_prefix, ((occ_vec + TABLE_DEPTH'(1)) & occ_vec) == '0, "gap in cells")
  `SKLT_ASSERT(a_insert_single, out_valid_o && out_item_o.status != sklt_pkg::STATUS_DRAINED |-> out_item_o.last && !out_item_o.entry_valid, "insert result not single")
  `SKLT_ASSERT(a_drain_empties, state_q == ST_DRAIN && state_d == ST_IDLE |=> !occ_vec[0], "table not empty after drain")

endmodule

`default_nettype wire
